// ===== rtl/gcsl_pkg.sv =====
// Shared types and constants of the Gray-code structured light decoder.
// Used by gcsl_accum, gcsl_decode and gray_code_structured_light_decoder_top.
// No dependencies.
package gcsl_pkg;

  localparam int unsigned CoordW   = 12;  // camera column and row
  localparam int unsigned ProjW    = 13;  // signed projector coordinates
  localparam int unsigned CfgDataW = 13;  // widest configuration register
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [12:0] ImageWidthRst = 13'd1024;
  localparam logic [11:0] UBiasRst      = 12'd64;
  localparam logic [11:0] VBiasRst      = 12'd484;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CROP_WIDTH  = 3'd0,
    REG_CROP_SHIFT  = 3'd1,
    REG_IMAGE_WIDTH = 3'd2,
    REG_PROJ_U_BIAS = 3'd3,
    REG_PROJ_V_BIAS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        [11:0] crop_width;
    logic signed [11:0] crop_shift;
    logic        [12:0] image_width;
    logic        [11:0] proj_u_bias;
    logic        [11:0] proj_v_bias;
  } cfg_t;

  // Per-pixel side information captured on the pixel's last pair.
  typedef struct packed {
    logic              pixel_ok;
    logic [CoordW-1:0] cam_column;
    logic [CoordW-1:0] cam_row;
  } pix_t;

endpackage

// ===== rtl/gcsl_accum.sv =====
// Gray bit accumulator: compares each intensity pair and shifts the bit into
// the vertical or horizontal Gray word; hands a finished pixel to the decoder.
// Depends on gcsl_pkg.
module gcsl_accum #(
  parameter int unsigned BITS_PER_AXIS = 11,
  parameter int unsigned LEVEL_WIDTH   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [LEVEL_WIDTH-1:0]    pattern_level_i,
  input  logic [LEVEL_WIDTH-1:0]    inverse_level_i,
  input  gcsl_pkg::pix_t            pix_i,
  input  logic                      s1_take_i,
  output logic                      s1_valid_o,
  output logic [BITS_PER_AXIS-1:0]  vert_gray_o,
  output logic [BITS_PER_AXIS-1:0]  horz_gray_o,
  output gcsl_pkg::pix_t            pix_o
);
  import gcsl_pkg::*;

  localparam int unsigned PairCnt = 2 * BITS_PER_AXIS;
  localparam int unsigned IdxW    = (PairCnt > 2) ? $clog2(PairCnt) : 1;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(PairCnt - 1);
  localparam logic [IdxW-1:0] HorzFrom = IdxW'(BITS_PER_AXIS);

  logic [IdxW-1:0]          pair_q, pair_d;
  logic [BITS_PER_AXIS-1:0] vg_q, vg_d, hg_q, hg_d, vg_shift, hg_shift;
  logic                     s1_valid_q, s1_valid_d;
  logic [BITS_PER_AXIS-1:0] s1_vg_q, s1_hg_q;
  pix_t                     s1_pix_q;
  logic                     accept, last, bit_v;

  assign in_stall_o = s1_valid_q && !s1_take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign last       = (pair_q == LastIdx);
  assign bit_v      = (pattern_level_i > inverse_level_i);
  assign vg_shift   = (vg_q << 1) | BITS_PER_AXIS'(bit_v);
  assign hg_shift   = (hg_q << 1) | BITS_PER_AXIS'(bit_v);

  always_comb begin
    pair_d     = pair_q;
    vg_d       = vg_q;
    hg_d       = hg_q;
    s1_valid_d = s1_valid_q && !s1_take_i;
    if (accept) begin
      if (last) begin
        pair_d     = '0;
        vg_d       = '0;
        hg_d       = '0;
        s1_valid_d = 1'b1;
      end else begin
        pair_d = pair_q + IdxW'(1);
        if (pair_q < HorzFrom) begin
          vg_d = vg_shift;
        end else begin
          hg_d = hg_shift;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q     <= '0;
      vg_q       <= '0;
      hg_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pair_q     <= pair_d;
      vg_q       <= vg_d;
      hg_q       <= hg_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // The last pair is always a horizontal one, so the vertical word is final.
  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      s1_vg_q  <= vg_q;
      s1_hg_q  <= hg_shift;
      s1_pix_q <= pix_i;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign vert_gray_o = s1_vg_q;
  assign horz_gray_o = s1_hg_q;
  assign pix_o       = s1_pix_q;

endmodule

// ===== rtl/gcsl_decode.sv =====
// Pixel decoder: mask and crop checks, Gray to binary conversion, bias
// subtraction and the result register. Depends on gcsl_pkg.
module gcsl_decode #(
  parameter int unsigned BITS_PER_AXIS = 11
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gcsl_pkg::cfg_t                       cfg_i,
  input  logic                                 s1_valid_i,
  output logic                                 s1_take_o,
  input  logic [BITS_PER_AXIS-1:0]             vert_gray_i,
  input  logic [BITS_PER_AXIS-1:0]             horz_gray_i,
  input  gcsl_pkg::pix_t                       pix_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [gcsl_pkg::CoordW-1:0]          match_column_o,
  output logic [gcsl_pkg::CoordW-1:0]          match_row_o,
  output logic signed [gcsl_pkg::ProjW-1:0]    proj_u_o,
  output logic signed [gcsl_pkg::ProjW-1:0]    proj_v_o
);
  import gcsl_pkg::*;

  localparam int unsigned DiffW = ((BITS_PER_AXIS > 12) ? BITS_PER_AXIS : 12) + 1;

  logic [BITS_PER_AXIS-1:0] vbin, hbin;
  logic [DiffW-1:0]         u_diff, v_diff;
  logic signed [15:0]       limit, iw_s, col_s;
  logic                     cropped, emit, out_ready;
  logic                     out_valid_q, out_valid_d;
  logic [CoordW-1:0]        col_q, row_q;
  logic [ProjW-1:0]         u_q, v_q;

  // Each binary bit is the parity of the Gray bits at and above it.
  always_comb begin
    for (int i = 0; i < BITS_PER_AXIS; i++) begin
      vbin[i] = ^(vert_gray_i >> i);
      hbin[i] = ^(horz_gray_i >> i);
    end
  end

  assign u_diff = DiffW'(vbin) - DiffW'(cfg_i.proj_u_bias);
  assign v_diff = DiffW'(hbin) - DiffW'(cfg_i.proj_v_bias);

  assign iw_s  = $signed({3'b000, cfg_i.image_width});
  assign col_s = $signed({4'b0000, pix_i.cam_column});
  assign limit = iw_s - $signed({4'b0000, cfg_i.crop_width})
               + $signed({{3{cfg_i.crop_shift[11]}}, cfg_i.crop_shift, 1'b0});

  assign cropped = (cfg_i.crop_width != '0) &&
                   ((pix_i.cam_column < cfg_i.crop_width) ||
                    ((limit < iw_s) && (col_s >= limit)));

  assign emit = pix_i.pixel_ok && !cropped &&
                (vert_gray_i != '0) && (horz_gray_i != '0);

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign s1_take_o   = s1_valid_i && out_ready;
  assign out_valid_d = s1_take_o ? emit : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take_o && emit) begin
      col_q <= pix_i.cam_column;
      row_q <= pix_i.cam_row;
      u_q   <= u_diff[ProjW-1:0];
      v_q   <= v_diff[ProjW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_column_o = col_q;
  assign match_row_o    = row_q;
  assign proj_u_o       = $signed(u_q);
  assign proj_v_o       = $signed(v_q);

endmodule

// ===== rtl/gray_code_structured_light_decoder_top.sv =====
// Channel   Signals                                   Direction
// request   in_valid_i / in_stall_o, pair fields      in
// match     out_valid_o / out_stall_i, match fields   out
// config    cfg_we_i, cfg_addr_i, cfg_wdata_i         in
//
// One intensity pair is taken per cycle while in_stall_o is low; a pixel takes 2*BITS_PER_AXIS pairs.
// After its pixel's last pair, a match passes through the capture register
// behind the accumulator and then through the result register.
// Reset clears the pair count and the Gray words and loads the configuration
// defaults.
// An out_stall_i holds the result; in_stall_o rises only when a captured
// pixel cannot move into a held result register.
// Top level of the Gray-code decoder; depends on gcsl_pkg, gcsl_accum, gcsl_decode.
module gray_code_structured_light_decoder_top #(
  parameter int unsigned BITS_PER_AXIS = 11,
  parameter int unsigned LEVEL_WIDTH   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gcsl_pkg::CfgIdxW-1:0]       cfg_addr_i,
  input  logic [gcsl_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [LEVEL_WIDTH-1:0]             pattern_level_i,
  input  logic [LEVEL_WIDTH-1:0]             inverse_level_i,
  input  logic                               pixel_ok_i,
  input  logic [gcsl_pkg::CoordW-1:0]        cam_column_i,
  input  logic [gcsl_pkg::CoordW-1:0]        cam_row_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [gcsl_pkg::CoordW-1:0]        match_column_o,
  output logic [gcsl_pkg::CoordW-1:0]        match_row_o,
  output logic signed [gcsl_pkg::ProjW-1:0]  proj_u_o,
  output logic signed [gcsl_pkg::ProjW-1:0]  proj_v_o
);
  import gcsl_pkg::*;

  cfg_t                     cfg_q;
  pix_t                     pix_in, s1_pix;
  logic                     s1_valid, s1_take;
  logic [BITS_PER_AXIS-1:0] s1_vg, s1_hg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crop_width  <= '0;
      cfg_q.crop_shift  <= '0;
      cfg_q.image_width <= ImageWidthRst;
      cfg_q.proj_u_bias <= UBiasRst;
      cfg_q.proj_v_bias <= VBiasRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CROP_WIDTH:  cfg_q.crop_width  <= cfg_wdata_i[11:0];
        REG_CROP_SHIFT:  cfg_q.crop_shift  <= $signed(cfg_wdata_i[11:0]);
        REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_wdata_i;
        REG_PROJ_U_BIAS: cfg_q.proj_u_bias <= cfg_wdata_i[11:0];
        REG_PROJ_V_BIAS: cfg_q.proj_v_bias <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  assign pix_in.pixel_ok   = pixel_ok_i;
  assign pix_in.cam_column = cam_column_i;
  assign pix_in.cam_row    = cam_row_i;

  gcsl_accum #(
    .BITS_PER_AXIS (BITS_PER_AXIS),
    .LEVEL_WIDTH   (LEVEL_WIDTH)
  ) u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pattern_level_i (pattern_level_i),
    .inverse_level_i (inverse_level_i),
    .pix_i           (pix_in),
    .s1_take_i       (s1_take),
    .s1_valid_o      (s1_valid),
    .vert_gray_o     (s1_vg),
    .horz_gray_o     (s1_hg),
    .pix_o           (s1_pix)
  );

  gcsl_decode #(
    .BITS_PER_AXIS (BITS_PER_AXIS)
  ) u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .s1_valid_i     (s1_valid),
    .s1_take_o      (s1_take),
    .vert_gray_i    (s1_vg),
    .horz_gray_i    (s1_hg),
    .pix_i          (s1_pix),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_column_o (match_column_o),
    .match_row_o    (match_row_o),
    .proj_u_o       (proj_u_o),
    .proj_v_o       (proj_v_o)
  );

endmodule
